/* rtl/npip_pkg.sv */
// ----------------------------------------------------------------------------
// npip_pkg
// Shared widths, register map, reset values and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package npip_pkg;

  // Field widths of one query and of the limit register
  localparam int unsigned START_W = 20;
  localparam int unsigned STEP_W  = 20;
  localparam int unsigned INDEX_W = 17;
  localparam int unsigned LIMIT_W = 20;

  // A term stays below the limit before a step is added, so it fits here
  localparam int unsigned WALK_W = 21;

  // Result width before any masking, and its default
  localparam int unsigned TERM_WIDTH_DEFAULT = 21;

  // Trial divisors never pass sqrt(2^WALK_W), one spare bit on top
  localparam int unsigned DIV_W = (WALK_W + 1) / 2 + 1;
  localparam int unsigned SQ_W  = 2 * DIV_W;

  // Restoring division: bits retired per cycle and division rounds per remainder
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_CYCLES = (WALK_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned DIVIDEND_W = DIV_CYCLES * DIV_STEPS;
  localparam int unsigned DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Stream input packing
  localparam int unsigned START_LSB  = 0;
  localparam int unsigned STEP_LSB   = START_LSB + START_W;
  localparam int unsigned INDEX_LSB  = STEP_LSB + STEP_W;
  localparam int unsigned IN_FIELDS_W = INDEX_LSB + INDEX_W;
  localparam int unsigned IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;

  // Register port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned REG_IDX_W  = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_SEARCH_LIMIT = '0;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET      = LIMIT_W'(1000000);

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture a new query
    logic q_init;     // first divisor is two
    logic q_adv;      // move to the next divisor
    logic div_init;   // start a remainder
    logic div_step;   // retire DIV_STEPS dividend bits
    logic count_inc;  // one more prime seen
    logic term_adv;   // add the step to the term
    logic out_load;   // place the result in the output register
    logic out_found;  // found flag of that result
  } npip_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic n_zero;     // index of zero asked for
    logic d_zero;     // progression does not move
    logic ge_limit;   // term at or above the search limit
    logic lt_two;     // term is zero or one
    logic sq_above;   // divisor squared passes the term
    logic div_last;   // last division cycle
    logic rem_zero;   // divisor divides the term
    logic count_hit;  // this prime is the wanted one
    logic out_busy;   // output register holds an untaken result
  } npip_sts_t;

endpackage

/* rtl/npip_dp.sv */
// ----------------------------------------------------------------------------
// npip_dp
// Datapath: query registers, term walk, divisor and its square, a
// multi-bit restoring remainder unit and the output register.
// ----------------------------------------------------------------------------
module npip_dp
  import npip_pkg::*;
#(
  parameter int unsigned TERM_WIDTH = TERM_WIDTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  npip_cmd_t             cmd_i,
  output npip_sts_t             sts_o,
  input  logic [START_W-1:0]    start_value_i,
  input  logic [STEP_W-1:0]     step_value_i,
  input  logic [INDEX_W-1:0]    prime_index_i,
  input  logic [LIMIT_W-1:0]    search_limit_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [TERM_WIDTH-1:0] prime_value_o,
  output logic                  found_o
);

  logic [WALK_W-1:0]     term_q;
  logic [STEP_W-1:0]     step_q;
  logic [INDEX_W-1:0]    index_q;
  logic [INDEX_W-1:0]    count_q;
  logic [DIV_W-1:0]      q_q;
  logic [SQ_W-1:0]       qsq_q;
  logic [DIV_W-1:0]      rem_q;
  logic [DIVIDEND_W-1:0] sh_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  out_valid_q;
  logic [TERM_WIDTH-1:0] out_value_q;
  logic                  out_found_q;

  logic [DIV_W-1:0]      rem_d;
  logic [DIVIDEND_W-1:0] sh_d;
  logic [DIV_W:0]        trial;

  // Retire DIV_STEPS dividend bits: shift in, compare, subtract
  always_comb begin
    rem_d = rem_q;
    sh_d  = sh_q;
    trial = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem_d, sh_d[DIVIDEND_W-1]};
      sh_d  = {sh_d[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, q_q}) begin
        trial = trial - {1'b0, q_q};
      end
      rem_d = trial[DIV_W-1:0];
    end
  end

  // Query, walk and divisor registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      term_q  <= WALK_W'(start_value_i);
      step_q  <= step_value_i;
      index_q <= prime_index_i;
      count_q <= '0;
    end else begin
      if (cmd_i.term_adv) begin
        term_q <= term_q + WALK_W'(step_q);
      end
      if (cmd_i.count_inc) begin
        count_q <= count_q + INDEX_W'(1);
      end
    end
    if (cmd_i.q_init) begin
      q_q   <= DIV_W'(2);
      qsq_q <= SQ_W'(4);
    end else if (cmd_i.q_adv) begin
      q_q   <= q_q + DIV_W'(1);
      qsq_q <= qsq_q + SQ_W'({q_q, 1'b1});
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      sh_q  <= DIVIDEND_W'(term_q);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      sh_q  <= sh_d;
    end
  end

  // Division cycle counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
    end
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q <= TERM_WIDTH'(term_q);
      out_found_q <= cmd_i.out_found;
    end
  end

  // Status toward the controller
  always_comb begin
    sts_o.n_zero    = (index_q == '0);
    sts_o.d_zero    = (step_q == '0);
    sts_o.ge_limit  = (term_q >= WALK_W'(search_limit_i));
    sts_o.lt_two    = (term_q < WALK_W'(2));
    sts_o.sq_above  = (qsq_q > SQ_W'(term_q));
    sts_o.div_last  = (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1));
    sts_o.rem_zero  = (rem_q == '0);
    sts_o.count_hit = ((count_q + INDEX_W'(1)) == index_q);
    sts_o.out_busy  = out_valid_q && !out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign prime_value_o = out_value_q;
  assign found_o       = out_found_q;

endmodule

/* rtl/npip_ctrl.sv */
// ----------------------------------------------------------------------------
// npip_ctrl
// Controller: steps one query through term checks, trial divisions and
// prime counting, then hands the result to the output register.
// ----------------------------------------------------------------------------
module npip_ctrl
  import npip_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  npip_sts_t sts_i,
  output npip_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_CHECK,
    ST_TEST,
    ST_DIV,
    ST_DIVCHK,
    ST_PRIME,
    ST_NOTPRIME,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   found_q, found_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    found_d    = found_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        if (sts_i.n_zero) begin
          found_d = 1'b0;
          state_d = ST_FINISH;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (sts_i.ge_limit) begin
          found_d = 1'b0;
          state_d = ST_FINISH;
        end else if (sts_i.lt_two) begin
          state_d = ST_NOTPRIME;
        end else begin
          cmd_o.q_init = 1'b1;
          state_d      = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts_i.sq_above) begin
          state_d = ST_PRIME;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DIVCHK;
        end
      end
      ST_DIVCHK: begin
        if (sts_i.rem_zero) begin
          state_d = ST_NOTPRIME;
        end else begin
          cmd_o.q_adv = 1'b1;
          state_d     = ST_TEST;
        end
      end
      ST_PRIME: begin
        // A progression that stands still succeeds on its first prime
        if (sts_i.count_hit || sts_i.d_zero) begin
          found_d = 1'b1;
          state_d = ST_FINISH;
        end else begin
          cmd_o.count_inc = 1'b1;
          cmd_o.term_adv  = 1'b1;
          state_d         = ST_CHECK;
        end
      end
      ST_NOTPRIME: begin
        if (sts_i.d_zero) begin
          found_d = 1'b0;
          state_d = ST_FINISH;
        end else begin
          cmd_o.term_adv = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_found = found_q;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and found flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
    end
  end

endmodule

/* rtl/nth_prime_in_progression_unit.sv */
// ----------------------------------------------------------------------------
// nth_prime_in_progression_unit
// Finds the n-th prime among a, a+d, a+2d, ... below a programmable limit,
// testing each term by trial division.
//
//   channel  dir  handshake              payload
//   s_*      in   s_tvalid / s_tready    s_tdata: start, step, index
//   m_*      out  m_tvalid / m_tready    m_tdata: prime_value, m_tuser: found
//   apb      in   psel, penable, pready  search_limit at byte address 0
//
// One query at a time. Each term is tried against divisors running from 2 up
// to sqrt(term), each passing the test, division and remainder check states;
// the restoring remainder unit retires 3 bits a cycle. Total latency is data
// dependent.
// Reset clears the controller and the output valid and loads search_limit
// with 1000000. A finished result waits in the output register while the
// next query is already accepted; only handing over the next result stalls.
// ----------------------------------------------------------------------------
module nth_prime_in_progression_unit
  import npip_pkg::*;
#(
  parameter int unsigned TERM_WIDTH = TERM_WIDTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Query stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [IN_TDATA_W-1:0]               s_tdata,  // start_value, step_value,
                                                         // prime_index, zero fill
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((TERM_WIDTH+7)/8)*8-1:0]     m_tdata,  // prime_value, zero fill
  output logic                                m_tuser,  // found
  // Register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [PADDR_W-1:0]                  paddr,
  input  logic [APB_DATA_W-1:0]               pwdata,
  output logic [APB_DATA_W-1:0]               prdata,
  output logic                                pready
);

  localparam int unsigned OUT_TDATA_W = ((TERM_WIDTH + 7) / 8) * 8;

  npip_cmd_t             cmd;
  npip_sts_t             sts;
  logic [LIMIT_W-1:0]    limit_q;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic [TERM_WIDTH-1:0] prime_value;

  // Register write and read
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_SEARCH_LIMIT)) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_SEARCH_LIMIT) ? APB_DATA_W'(limit_q) : '0;

  npip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  npip_dp #(
    .TERM_WIDTH (TERM_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .start_value_i  (s_tdata[START_LSB +: START_W]),
    .step_value_i   (s_tdata[STEP_LSB +: STEP_W]),
    .prime_index_i  (s_tdata[INDEX_LSB +: INDEX_W]),
    .search_limit_i (limit_q),
    .out_ready_i    (m_tready),
    .out_valid_o    (m_tvalid),
    .prime_value_o  (prime_value),
    .found_o        (m_tuser)
  );

  assign m_tdata = OUT_TDATA_W'(prime_value);

endmodule

/* rtl/npip_checker.sv */
// ----------------------------------------------------------------------------
// npip_checker
// Port-level checks on the query and result streams, bound to the top.
// ----------------------------------------------------------------------------
module npip_checker
  import npip_pkg::*;
#(
  parameter int unsigned TERM_WIDTH = TERM_WIDTH_DEFAULT
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [((TERM_WIDTH+7)/8)*8-1:0] m_tdata,
  input logic                            m_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // One query in flight: no transfer right after a transfer
  a_one_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("query accepted while another is in flight");

  // A found result is a prime, so at least two
  a_found_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser |-> m_tdata >= 2)
    else $error("found result below two");

endmodule

bind nth_prime_in_progression_unit npip_checker #(
  .TERM_WIDTH (TERM_WIDTH)
) u_npip_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Exercises nth_prime_in_progression_unit. Queries go in through the s_*
// stream and results come back on the m_* stream. A local model walks the
// same arithmetic progression and counts primes by trial division. Every
// result is checked against the oldest pending prediction. The search limit
// is reprogrammed over APB between phases, down to two and up to its maximum.
// The phases use different amounts of idling on the sender and the
// receiver, and one phase holds the receiver off long enough to back up
// the input.
// ----------------------------------------------------------------------------
module testbench
  import npip_pkg::*;
;

  localparam int unsigned OUT_TDATA_W  = ((TERM_WIDTH_DEFAULT + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT  = 20_000_000;
  localparam int unsigned HOLD_CYCLES  = 4000;
  localparam int unsigned SETTLE_WAIT  = 50;
  localparam int unsigned MAX_REPORTED = 10;
  localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_SEARCH_LIMIT, 2'b00};

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [STEP_W-1:0]  step;
    logic [START_W-1:0] start;
  } prime_query_t;

  typedef struct packed {
    logic [WALK_W-1:0] value;
    logic              found;
  } prime_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // start_value, step_value, prime_index, zero fill
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // prime_value, zero fill
  logic                   m_tuser;   // found
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  // Model copy of the limit register and the results still to come
  logic [LIMIT_W-1:0] limit_q;
  prime_result_t      pending_primes[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        receiver_hold;
  int unsigned mismatch_count;
  int unsigned cycle_count;

  nth_prime_in_progression_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic bit term_is_prime(int unsigned term);
    int unsigned dv;
    if (term < 2) return 1'b0;
    for (dv = 2; dv * dv <= term; dv++) begin
      if (term % dv == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Walk the progression and stop at the wanted prime or at the limit
  function automatic prime_result_t find_progression_prime(prime_query_t q);
    int unsigned   term;
    int unsigned   count;
    bit            hit;
    prime_result_t res;
    term  = q.start;
    count = 0;
    hit   = 1'b0;
    if (q.index != 0 && q.step == 0) begin
      // Stationary progression: only the start itself can be the answer
      if (term < limit_q && term_is_prime(term)) hit = 1'b1;
    end else if (q.index != 0) begin
      while (term < limit_q) begin
        if (term_is_prime(term)) begin
          count++;
          if (count == q.index) begin
            hit = 1'b1;
            break;
          end
        end
        term += q.step;
      end
    end
    res.value = term[WALK_W-1:0];
    res.found = hit;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, optional long hold-off, and checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_results
    prime_result_t want;
    if (rst_ni) begin
      m_tready <= !receiver_hold && ($urandom_range(99) >= recv_stall_pct);
      if (m_tvalid && m_tready) begin
        if (pending_primes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED)
            $display("ERROR: result with nothing pending: prime_value %0d found %0b",
                     m_tdata, m_tuser);
        end else begin
          want = pending_primes.pop_front();
          if (m_tdata !== OUT_TDATA_W'(want.value) || m_tuser !== want.found) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
              $display("ERROR: prime_value exp %0d got %0d, found exp %0b got %0b",
                       want.value, m_tdata, want.found, m_tuser);
          end
        end
      end
    end else begin
      m_tready <= 1'b0;
    end
  end

  // Hold the receiver off for a counted stretch
  task automatic hold_off_results(int unsigned cycles);
    receiver_hold <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    receiver_hold <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Query side and register port
  // ---------------------------------------------------------------------------

  // Offer one query, wait for its transfer and record the prediction
  task automatic send_query(prime_query_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(q);
    do @(posedge clk_i); while (!s_tready);
    pending_primes.push_back(find_progression_prime(q));
  endtask

  task automatic send_fields(int unsigned start, int unsigned step, int unsigned index);
    prime_query_t q;
    q.start = START_W'(start);
    q.step  = STEP_W'(step);
    q.index = INDEX_W'(index);
    send_query(q);
  endtask

  // Drop valid and wait until every pending result has been taken
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_primes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  // Program the search limit; call only while the unit is idle
  task automatic write_search_limit(int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_q = LIMIT_W'(value);
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and the special cases, under several limits
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Reset value of the limit
    send_fields(999983, 0, 1);
    send_fields(1000000, 1, 1);
    send_fields(0, 1, 3);             // zero and one are skipped as non-prime
    send_fields(1, 0, 1);             // stationary at one
    send_fields(7, 0, 131071);        // stationary at a prime
    send_fields(8, 0, 5);             // stationary at a composite
    send_fields(5, 3, 0);             // zero index, no walk
    send_fields(0, 0, 0);
    drain_results();
    // Largest limit
    write_search_limit(1048575);
    send_fields(1048575, 1048575, 131071);
    send_fields(1048574, 1048575, 131071);  // overshoot into the top term bit
    send_fields(1048573, 0, 1);
    send_fields(1000000, 1, 2);
    drain_results();
    // Limit of two, below which no prime lies
    write_search_limit(2);
    send_fields(1, 1, 1);
    send_fields(0, 1, 131071);
    send_fields(2, 0, 1);
    drain_results();
    write_search_limit(100);
    send_fields(2, 1, 25);
    send_fields(2, 1, 26);
    send_fields(3, 2, 10);
    send_fields(1, 6, 4);
    send_fields(4, 2, 1);             // even walk never meets a prime
    send_fields(2, 99, 1);
    send_fields(97, 1048575, 2);
    drain_results();
  endtask

  // Block the result side while queries keep coming
  task automatic test_backpressure_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_search_limit(200);
    fork
      hold_off_results(HOLD_CYCLES);
    join_none
    repeat (14)
      send_fields($urandom_range(300, 1), $urandom_range(30, 1), $urandom_range(3, 1));
    drain_results();
  endtask

  // Mostly well-formed walks, plus random noise and the special cases
  task automatic test_random_queries(int unsigned limit, int unsigned idle_pct,
                                     int unsigned stall_pct, int unsigned count);
    prime_query_t q;
    int unsigned  sel;
    write_search_limit(limit);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 65) begin
        q.start = START_W'($urandom_range(limit, 1));
        q.step  = STEP_W'($urandom_range(40, 1));
        q.index = INDEX_W'($urandom_range(6, 1));
      end else if (sel < 75) begin
        q.start = START_W'($urandom_range(limit, 0));
        q.step  = STEP_W'($urandom());
        q.index = INDEX_W'($urandom());
      end else if (sel < 85) begin
        q.start = START_W'($urandom());
        q.step  = STEP_W'($urandom());
        q.index = INDEX_W'($urandom());
      end else if (sel < 93) begin
        q.start = START_W'($urandom_range(limit, 0));
        q.step  = '0;
        q.index = INDEX_W'($urandom());
      end else begin
        q.start = START_W'($urandom());
        q.step  = STEP_W'($urandom());
        q.index = '0;
      end
      send_query(q);
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni         <= 1'b0;
    s_tvalid       <= 1'b0;
    s_tdata        <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    receiver_hold  <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    limit_q        = LIMIT_RESET;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_backpressure_fill();
    test_random_queries(1000, 0, 0, 16);
    test_random_queries(300, 60, 0, 16);
    test_random_queries(4096, 0, 60, 16);
    test_random_queries(600, 13, 13, 16);

    drain_results();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
